// ===== hdl/sitda_pkg.sv =====
// Shared constants and types for the signed integer to decimal text converter.
package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // Control shared by every digit cell in the chain.
    typedef struct packed {
        logic clear;   // load a new number: all digits to zero
        logic dabble;  // add-3 adjust, then shift one binary bit in
        logic shift;   // move every digit one place toward the top cell
    } cell_ctrl_t;

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII text, most significant character first.
//
//  channel | ports                                   | direction | beat
//  --------+-----------------------------------------+-----------+------------------------
//  input   | s_valid, s_ready, s_value[31:0]         | in        | one integer
//  result  | m_valid, m_ready, m_text_char[5:0], m_last | out    | one character, last flag
//
// Flow: an integer is taken in IDLE, shifted into NDIG BCD cells one bit per cycle,
// then leading zeros are shifted out and one character leaves per cycle while the
// output register is free or m_ready takes it; a minus, if any, leaves first.
// Reset: synchronous active-low aresetn returns the FSM to IDLE and drops m_valid.
// Stalls: m_ready low holds the output register; the chain waits with it. The next
// integer may be taken while the final character still waits in the output register.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_text_char,
    output logic        m_last
);

    // Digits of 2^(VALUE_WIDTH-1), the largest magnitude.
    localparam int NDIG     = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BitCntW  = $clog2(VALUE_WIDTH + 1);
    localparam int DigCntW  = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BitCntW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DigCntW-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                 sign_reg, sign_next;
    logic                 m_valid_reg, m_valid_next;
    logic [5:0]           m_text_char_reg, m_text_char_next;
    logic                 m_last_reg, m_last_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] raw_mag;
    logic                 load;
    logic                 emit_slot;
    logic                 emit_digit;
    logic                 strip_shift;
    logic [3:0]           top_digit;
    cell_ctrl_t           ctrl;

    logic [3:0] digit_w [NDIG];
    logic       carry_w [NDIG];

    // Bits above the configured width are ignored.
    generate
        if (VALUE_WIDTH <= 32) begin : g_narrow
            assign raw = s_value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign raw = {{(VALUE_WIDTH - 32){1'b0}}, s_value};
        end
    endgenerate

    // Two's complement negate; the most negative value lands on 2^(W-1) unsigned.
    assign raw_mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    assign s_ready   = (state_reg == ST_IDLE);
    assign load      = s_valid && s_ready;
    assign top_digit = digit_w[NDIG-1];

    assign emit_slot   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_digit  = emit_slot && !sign_reg;
    assign strip_shift = (state_reg == ST_STRIP) && (top_digit == 4'd0)
                         && (dig_cnt_reg > DigCntW'(1));

    assign ctrl.clear  = load;
    assign ctrl.dabble = (state_reg == ST_CONV);
    assign ctrl.shift  = strip_shift || emit_digit;

    // Cell 0 is the ones digit; carries and digits flow toward the top cell.
    generate
        for (genvar i = 0; i < NDIG; i++) begin : g_cell
            logic       bit_in_w;
            logic [3:0] digit_in_w;
            if (i == 0) begin : g_first
                assign bit_in_w   = mag_reg[VALUE_WIDTH-1];
                assign digit_in_w = 4'd0;
            end else begin : g_rest
                assign bit_in_w   = carry_w[i-1];
                assign digit_in_w = digit_w[i-1];
            end
            sitda_bcd_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .bit_in    (bit_in_w),
                .digit_in  (digit_in_w),
                .digit     (digit_w[i]),
                .carry_out (carry_w[i])
            );
        end
    endgenerate

    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        bit_cnt_next     = bit_cnt_reg;
        dig_cnt_next     = dig_cnt_reg;
        sign_next        = sign_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_text_char_next = m_text_char_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    mag_next     = raw_mag;
                    sign_next    = raw[VALUE_WIDTH-1];
                    bit_cnt_next = BitCntW'(VALUE_WIDTH);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BitCntW'(1)) begin
                    dig_cnt_next = DigCntW'(NDIG);
                    state_next   = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (strip_shift) begin
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_slot) begin
                    m_valid_next = 1'b1;
                    if (sign_reg) begin
                        m_text_char_next = CHAR_MINUS;
                        m_last_next      = 1'b0;
                        sign_next        = 1'b0;
                    end else begin
                        m_text_char_next = CHAR_ZERO + {2'b00, top_digit};
                        m_last_next      = (dig_cnt_reg == DigCntW'(1));
                        dig_cnt_next     = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == DigCntW'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg         <= mag_next;
        bit_cnt_reg     <= bit_cnt_next;
        dig_cnt_reg     <= dig_cnt_next;
        sign_reg        <= sign_next;
        m_text_char_reg <= m_text_char_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_text_char = m_text_char_reg;
    assign m_last      = m_last_reg;

endmodule

// ===== hdl/sitda_bcd_cell.sv =====
// One BCD digit cell of the shift-and-add-3 chain.
module sitda_bcd_cell
    import sitda_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,     // carry from the next lower cell
    input  logic [3:0] digit_in,   // digit of the next lower cell
    output logic [3:0] digit,
    output logic       carry_out
);

    logic [3:0] digit_reg;
    logic [3:0] adj;

    // Adjust by 3 when the digit would overflow past 9 on doubling.
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge aclk) begin
        priority if (ctrl.clear) begin
            digit_reg <= 4'd0;
        end else if (ctrl.dabble) begin
            digit_reg <= {adj[2:0], bit_in};
        end else if (ctrl.shift) begin
            digit_reg <= digit_in;
        end
    end

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking bench for signed_int_to_decimal_ascii: drives integers, checks the decimal text beats.
module signed_int_to_decimal_ascii_tb
    import sitda_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 44;      // per idling phase, three phases
    localparam int TAIL_CYCLES  = 60;      // longer than one integer's worst case without back-pressure
    localparam int CYCLE_LIMIT  = 500000;  // far above the slowest legal run

    // One character beat on the result channel.
    typedef struct packed {
        logic [5:0] text_char;
        logic       last;
    } char_beat_t;

    // Directed row: an empty text means the expected beats come from the predictor.
    typedef struct {
        logic [31:0] value;
        string       text;
    } directed_row_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_text_char;
    logic        m_last;

    // Characters still owed by the block, oldest first.
    char_beat_t  text_pending[$];
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;

    // Zero, sign extremes, one- and ten-digit boundaries, the eleven-beat maximum,
    // and alternating bit patterns and other values left to the predictor.
    directed_row_t directed_rows[20] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'hFFFF_FFFF,  "-1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{32'hFFFF_FFF6,  "-10"},
        '{32'd100,        "100"},
        '{32'hFFFF_FF9C,  "-100"},
        '{32'd999999999,  "999999999"},
        '{32'd1000000000, "1000000000"},
        '{32'hC465_3600,  "-1000000000"},
        '{32'h7FFF_FFFF,  "2147483647"},
        '{32'h8000_0000,  "-2147483648"},  // magnitude does not fit in 31 bits
        '{32'h8000_0001,  "-2147483647"},
        '{32'hAAAA_AAAA,  ""},
        '{32'h5555_5555,  ""},
        '{32'h1234_5678,  ""},
        '{32'hDEAD_BEEF,  ""},
        '{32'd4294967,    ""},
        '{32'hFFFF_FC18,  ""}
    };

    signed_int_to_decimal_ascii dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Predictor: sign, then magnitude digits most significant first, last on the final one.
    // Negating in 32 bits keeps 2^31 intact as an unsigned magnitude.
    function automatic void push_decimal_text(input logic [31:0] value);
        logic [31:0] magnitude;
        logic [5:0]  digits[$];
        magnitude = value[31] ? (~value + 32'd1) : value;
        do begin
            digits.push_front(CHAR_ZERO + 6'(magnitude % 32'd10));
            magnitude = magnitude / 32'd10;
        end while (magnitude != 0);
        if (value[31])
            text_pending.push_back('{text_char: CHAR_MINUS, last: 1'b0});
        foreach (digits[i])
            text_pending.push_back('{text_char: digits[i], last: (i == digits.size() - 1)});
    endfunction

    // Expected beats typed in as plain text; ASCII '-' and digits fit in six bits.
    function automatic void push_typed_text(input string text);
        byte ch;
        for (int i = 0; i < text.len(); i++) begin
            ch = text[i];
            text_pending.push_back('{text_char: ch[5:0], last: (i == text.len() - 1)});
        end
    endfunction

    // Random values: full range, small magnitudes, values around powers of ten, and the two extremes.
    function automatic logic [31:0] pick_value();
        int unsigned mode;
        logic [31:0] v;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            v = $urandom;
        end else if (mode < 7) begin
            v = $urandom_range(0, 999);
            if ($urandom_range(0, 1)) v = -v;
        end else if (mode < 9) begin
            v = 32'd1;
            repeat ($urandom_range(0, 9)) v = v * 32'd10;
            v = v - $urandom_range(0, 1);
            if ($urandom_range(0, 1)) v = -v;
        end else begin
            v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v;
    endfunction

    // Offer one integer; random gaps before it, valid held until the beat is taken.
    task automatic send_value(input logic [31:0] value, input string text);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        if (text.len() != 0)
            push_typed_text(text);
        else
            push_decimal_text(value);
    endtask

    // Sender holds off until every owed character has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (text_pending.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, and every accepted beat checked against the oldest owed one.
    always @(posedge aclk) begin : result_check
        char_beat_t want;
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (text_pending.size() == 0) begin
                $error("unexpected beat: text_char %0d last %0d", m_text_char, m_last);
                fail_count++;
            end else begin
                want = text_pending.pop_front();
                if (m_text_char !== want.text_char) begin
                    $error("text_char: expected %0d, got %0d", want.text_char, m_text_char);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Three idling phases: sender sparse / receiver heavy, swapped, then none.
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 73 : 0;
            sink_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 11 : 0;
            if (phase == 0) begin
                foreach (directed_rows[i])
                    send_value(directed_rows[i].value, directed_rows[i].text);
                wait_drained();
            end
            for (int n = 0; n < RANDOM_ITEMS; n++)
                send_value(pick_value(), "");
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && text_pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
